/* rtl/core/ppsa_pkg.sv */
package ppsa_pkg;

    localparam int NUM_PAGES_DEF       = 64;
    localparam int SLOT_COUNT_DEF      = 64;
    localparam int MAX_ALLOC_PAGES_DEF = 16;
    localparam int PAGE_BYTES_DEF      = 4096;

    localparam int OFF_W  = 18;
    localparam int SIZE_W = 19;
    localparam int CNT_W  = 7;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_SCAN_WAIT,
        S_SLOT,
        S_SLOT_WAIT,
        S_OWN_RD,
        S_OWN_WAIT,
        S_REC_WAIT,
        S_RANGE,
        S_RANGE_WAIT,
        S_FILL,
        S_DONE
    } t_state;

endpackage

/* rtl/core/page_pool_suballocator_unit.sv */
// First-fit page suballocator. Requests (allocate, free, lookup) are served
// one at a time; each gives one result transfer. State lives in two memories
// (page owner tags, slot records) with registered reads; each read address
// is held while its data is consumed. Allocate scans the owner tags for the
// first free run of pages, then the slot records for the first free slot,
// then tags each page of the run; free reads the tag of the first page and
// its slot record, then clears each page of the allocation; lookup reads the
// tag of each page the range spans and the owning slot record. Rejected
// requests end sooner. Reset starts a clearing pass through every entry of
// both memories, during which no request is accepted. A new request is
// accepted only once the previous result has been taken or is taken in the
// same cycle.
module page_pool_suballocator_unit #(
    parameter int NUM_PAGES       = ppsa_pkg::NUM_PAGES_DEF,
    parameter int SLOT_COUNT      = ppsa_pkg::SLOT_COUNT_DEF,
    parameter int MAX_ALLOC_PAGES = ppsa_pkg::MAX_ALLOC_PAGES_DEF,
    parameter int PAGE_BYTES      = ppsa_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [17:0] i_byte_offset,
    input  logic [18:0] i_byte_size,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [17:0] o_result_offset,
    output logic [18:0] o_result_length,
    output logic [6:0]  o_live_count,
    output logic [6:0]  o_pages_busy
);
    localparam int PW  = $clog2(NUM_PAGES);
    localparam int SW  = $clog2(SLOT_COUNT);
    localparam int OW  = $clog2(SLOT_COUNT + 1);   // owner tag width
    localparam int BW  = $clog2(PAGE_BYTES);       // byte-in-page bits
    localparam int NW  = $clog2(NUM_PAGES + 1);    // page count width
    localparam int RW  = 1 + PW + NW;              // slot record width
    localparam int CLR = (NUM_PAGES > SLOT_COUNT) ? NUM_PAGES : SLOT_COUNT;
    localparam int CW  = $clog2(CLR + 1);
    localparam int AW  = 40;                       // wide byte arithmetic

    localparam logic [AW-1:0] POOL_BYTES = AW'(NUM_PAGES) * AW'(PAGE_BYTES);

    ppsa_pkg::t_state r_state, n_state;

    // request registers
    logic [1:0]    r_op,   n_op;
    logic [AW-1:0] r_off,  n_off;
    logic [AW-1:0] r_size, n_size;
    logic [AW-1:0] r_need, n_need;     // rounded page count
    logic [NW:0]   r_p,    n_p;        // page cursor
    logic [NW:0]   r_run,  n_run;
    logic [NW:0]   r_start, n_start;
    logic [NW:0]   r_last, n_last;
    logic [SW:0]   r_s,    n_s;        // slot cursor
    logic [OW-1:0] r_own,  n_own;
    logic [OW-1:0] r_fill, n_fill;     // tag written during fill
    logic [NW-1:0] r_rcnt, n_rcnt;
    logic [PW-1:0] r_rfirst, n_rfirst;
    logic [CW-1:0] r_clr, n_clr;
    logic          r_clr_run, n_clr_run;

    logic [6:0]    r_live, n_live;
    logic [6:0]    r_busy, n_busy;
    logic [6:0]    r_limit;

    // result register
    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_st, n_st;
    logic [17:0]   r_roff, n_roff;
    logic [18:0]   r_rlen, n_rlen;

    // page owner memory
    logic          own_we;
    logic [PW-1:0] own_waddr, own_raddr;
    logic [OW-1:0] own_wdata, own_rdata;

    ppsa_owner_mem #(.DEPTH(NUM_PAGES), .W(OW)) u_owner (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_waddr(own_waddr),
        .i_wdata(own_wdata),
        .i_raddr(own_raddr),
        .o_rdata(own_rdata)
    );

    // slot record memory {used, first, count}
    logic          rec_we;
    logic [SW-1:0] rec_waddr, rec_raddr;
    logic [RW-1:0] rec_wdata, rec_rdata;

    ppsa_owner_mem #(.DEPTH(SLOT_COUNT), .W(RW)) u_slot (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(rec_waddr),
        .i_wdata(rec_wdata),
        .i_raddr(rec_raddr),
        .o_rdata(rec_rdata)
    );

    logic          rec_used;
    logic [PW-1:0] rec_first;
    logic [NW-1:0] rec_count;
    assign rec_used  = rec_rdata[RW-1];
    assign rec_first = rec_rdata[NW +: PW];
    assign rec_count = rec_rdata[NW-1:0];

    logic accept;
    assign o_ready = (r_state == ppsa_pkg::S_IDLE) && !r_clr_run
                     && (!r_ovalid || i_ready);
    assign accept  = i_valid && o_ready;

    logic [AW-1:0] a_start, a_end;
    assign a_start = AW'(rec_first) * AW'(PAGE_BYTES);
    assign a_end   = a_start + AW'(rec_count) * AW'(PAGE_BYTES);

    logic [AW-1:0] sz_pages;
    assign sz_pages = (AW'(i_byte_size) + AW'(PAGE_BYTES - 1)) >> BW;

    always_comb begin
        n_state = r_state;
        n_op = r_op; n_off = r_off; n_size = r_size; n_need = r_need;
        n_p = r_p; n_run = r_run; n_start = r_start; n_last = r_last;
        n_s = r_s; n_own = r_own; n_fill = r_fill;
        n_rcnt = r_rcnt; n_rfirst = r_rfirst;
        n_clr = r_clr; n_clr_run = r_clr_run;
        n_live = r_live; n_busy = r_busy;
        n_ovalid = r_ovalid; n_st = r_st; n_roff = r_roff; n_rlen = r_rlen;
        own_we = 1'b0; own_waddr = '0; own_wdata = '0; own_raddr = '0;
        rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        // clearing pass after reset
        if (r_clr_run) begin
            own_we    = (r_clr < CW'(NUM_PAGES));
            own_waddr = PW'(r_clr);
            rec_we    = (r_clr < CW'(SLOT_COUNT));
            rec_waddr = SW'(r_clr);
            n_clr     = r_clr + 1'b1;
            if (r_clr == CW'(CLR - 1)) begin
                n_clr_run = 1'b0;
            end
        end

        unique case (r_state)
            ppsa_pkg::S_IDLE: begin
                if (accept) begin
                    n_op    = i_opcode;
                    n_off   = AW'(i_byte_offset);
                    n_size  = AW'(i_byte_size);
                    n_need  = sz_pages;
                    n_state = ppsa_pkg::S_CHECK;
                end
            end
            ppsa_pkg::S_CHECK: begin
                n_st = ppsa_pkg::ST_INVALID;
                n_state = ppsa_pkg::S_DONE;
                n_p = '0; n_run = '0; n_s = '0;
                priority case (r_op)
                    ppsa_pkg::OP_ALLOC: begin
                        if (r_size == '0) begin
                            n_st = ppsa_pkg::ST_INVALID;
                        end else if (r_live >= r_limit
                                     || 32'(r_live) >= SLOT_COUNT) begin
                            n_st = ppsa_pkg::ST_NOSPACE;
                        end else if (r_need > AW'(MAX_ALLOC_PAGES)
                                     || r_need > AW'(NUM_PAGES)) begin
                            n_st = ppsa_pkg::ST_INVALID;
                        end else begin
                            own_raddr = '0;
                            n_state = ppsa_pkg::S_SCAN_WAIT;
                        end
                    end
                    ppsa_pkg::OP_FREE, ppsa_pkg::OP_LOOKUP: begin
                        if (r_off >= POOL_BYTES) begin
                            n_st = ppsa_pkg::ST_OUTSIDE;
                        end else if (r_size == '0) begin
                            n_st = ppsa_pkg::ST_INVALID;
                        end else if (r_op == ppsa_pkg::OP_LOOKUP
                                     && r_off + r_size > POOL_BYTES) begin
                            n_st = ppsa_pkg::ST_OUTSIDE;
                        end else begin
                            n_p = (NW+1)'(r_off >> BW);
                            // free checks only the first page
                            n_last = (r_op == ppsa_pkg::OP_FREE)
                                   ? (NW+1)'(r_off >> BW)
                                   : (NW+1)'((r_off + r_size - 1'b1) >> BW);
                            own_raddr = PW'(r_off >> BW);
                            n_state = ppsa_pkg::S_OWN_WAIT;
                        end
                    end
                    default: n_st = ppsa_pkg::ST_INVALID;
                endcase
            end
            ppsa_pkg::S_SCAN_WAIT: begin
                // hold the address so the tag stays valid for the scan step
                own_raddr = PW'(r_p);
                n_state = ppsa_pkg::S_SCAN;
            end
            ppsa_pkg::S_SCAN: begin
                // own_rdata holds tag of page r_p
                if (own_rdata != '0) begin
                    n_run = '0;
                end else begin
                    n_run = r_run + 1'b1;
                end
                if (own_rdata == '0 && AW'(r_run + 1'b1) == r_need) begin
                    n_start = r_p + 1'b1 - (r_run + 1'b1);
                    rec_raddr = '0;
                    n_state = ppsa_pkg::S_SLOT_WAIT;
                end else if (r_p == (NW+1)'(NUM_PAGES - 1)) begin
                    n_st = ppsa_pkg::ST_NOSPACE;
                    n_state = ppsa_pkg::S_DONE;
                end else begin
                    n_p = r_p + 1'b1;
                    own_raddr = PW'(r_p + 1'b1);
                    n_state = ppsa_pkg::S_SCAN_WAIT;
                end
            end
            ppsa_pkg::S_SLOT_WAIT: begin
                rec_raddr = SW'(r_s);
                n_state = ppsa_pkg::S_SLOT;
            end
            ppsa_pkg::S_SLOT: begin
                if (!rec_used) begin
                    rec_we    = 1'b1;
                    rec_waddr = SW'(r_s);
                    rec_wdata = {1'b1, PW'(r_start), NW'(r_need)};
                    n_fill    = OW'(r_s + 1'b1);
                    n_p       = r_start;
                    n_last    = r_start + (NW+1)'(r_need) - 1'b1;
                    n_rfirst  = PW'(r_start);
                    n_rcnt    = NW'(r_need);
                    n_st      = ppsa_pkg::ST_OK;
                    n_live    = r_live + 1'b1;
                    n_busy    = r_busy + 7'(r_need);
                    n_state   = ppsa_pkg::S_FILL;
                end else if (r_s == (SW+1)'(SLOT_COUNT - 1)) begin
                    n_st = ppsa_pkg::ST_NOSPACE;
                    n_state = ppsa_pkg::S_DONE;
                end else begin
                    n_s = r_s + 1'b1;
                    rec_raddr = SW'(r_s + 1'b1);
                    n_state = ppsa_pkg::S_SLOT_WAIT;
                end
            end
            ppsa_pkg::S_OWN_WAIT: begin
                own_raddr = PW'(r_p);
                n_state = ppsa_pkg::S_OWN_RD;
            end
            ppsa_pkg::S_OWN_RD: begin
                n_own = own_rdata;
                if (own_rdata == '0 || 32'(own_rdata) > SLOT_COUNT) begin
                    n_st = ppsa_pkg::ST_INVALID;
                    n_state = ppsa_pkg::S_DONE;
                end else begin
                    rec_raddr = SW'(own_rdata - 1'b1);
                    n_state = ppsa_pkg::S_REC_WAIT;
                end
            end
            ppsa_pkg::S_REC_WAIT: begin
                n_state = ppsa_pkg::S_RANGE;
                rec_raddr = SW'(r_own - 1'b1);
                n_rfirst = rec_first;
                n_rcnt = rec_count;
                if (r_p != r_last) begin
                    own_raddr = PW'(r_p + 1'b1);
                    n_p = r_p + 1'b1;
                    n_state = ppsa_pkg::S_RANGE_WAIT;
                end
            end
            ppsa_pkg::S_RANGE_WAIT: begin
                own_raddr = PW'(r_p);
                rec_raddr = SW'(r_own - 1'b1);
                n_state = ppsa_pkg::S_RANGE;
            end
            ppsa_pkg::S_RANGE: begin
                // rec data held stable by rec_raddr
                rec_raddr = SW'(r_own - 1'b1);
                if (r_p != (NW+1)'(r_off >> BW) && own_rdata != r_own) begin
                    n_st = ppsa_pkg::ST_INVALID;
                    n_state = ppsa_pkg::S_DONE;
                end else if (r_p != r_last) begin
                    own_raddr = PW'(r_p + 1'b1);
                    n_p = r_p + 1'b1;
                    n_state = ppsa_pkg::S_RANGE_WAIT;
                end else begin
                    n_state = ppsa_pkg::S_DONE;
                    if (!rec_used || r_off < a_start
                        || r_off + ((r_op == ppsa_pkg::OP_FREE) ? AW'(1) : r_size)
                           > a_end) begin
                        n_st = ppsa_pkg::ST_INVALID;
                    end else if (r_op == ppsa_pkg::OP_LOOKUP) begin
                        n_st = ppsa_pkg::ST_OK;
                    end else if (r_off != a_start || r_need != AW'(rec_count)) begin
                        n_st = ppsa_pkg::ST_INVALID;
                    end else begin
                        n_st = ppsa_pkg::ST_OK;
                        rec_we = 1'b1;
                        rec_waddr = SW'(r_own - 1'b1);
                        rec_wdata = '0;
                        n_fill = '0;
                        n_p = (NW+1)'(rec_first);
                        n_last = (NW+1)'(rec_first) + (NW+1)'(rec_count) - 1'b1;
                        n_live = r_live - 1'b1;
                        n_busy = r_busy - 7'(rec_count);
                        n_state = ppsa_pkg::S_FILL;
                    end
                end
            end
            ppsa_pkg::S_FILL: begin
                own_we = 1'b1;
                own_waddr = PW'(r_p);
                own_wdata = r_fill;
                n_p = r_p + 1'b1;
                if (r_p == r_last) begin
                    n_state = ppsa_pkg::S_DONE;
                end
            end
            ppsa_pkg::S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_roff = '0;
                    n_rlen = '0;
                    if (r_st == ppsa_pkg::ST_OK) begin
                        n_roff = 18'(AW'(r_rfirst) * AW'(PAGE_BYTES));
                        n_rlen = 19'(AW'(r_rcnt) * AW'(PAGE_BYTES));
                    end
                    n_state = ppsa_pkg::S_IDLE;
                end
            end
            default: n_state = ppsa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppsa_pkg::S_IDLE;
            r_clr     <= '0;
            r_clr_run <= 1'b1;
            r_live    <= '0;
            r_busy    <= '0;
            r_limit   <= 7'd64;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_run <= n_clr_run;
            r_live    <= n_live;
            r_busy    <= n_busy;
            r_ovalid  <= n_ovalid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_off <= n_off; r_size <= n_size; r_need <= n_need;
        r_p <= n_p; r_run <= n_run; r_start <= n_start; r_last <= n_last;
        r_s <= n_s; r_own <= n_own; r_fill <= n_fill;
        r_rcnt <= n_rcnt; r_rfirst <= n_rfirst;
        r_st <= n_st; r_roff <= n_roff; r_rlen <= n_rlen;
    end

    // live and busy counts reported as of result creation
    logic [6:0] r_olive, r_obusy;
    always_ff @(posedge i_clk) begin
        if (r_state == ppsa_pkg::S_DONE && (!r_ovalid || i_ready)) begin
            r_olive <= r_live;
            r_obusy <= r_busy;
        end
    end

    logic [1:0] r_st_out;
    always_ff @(posedge i_clk) begin
        if (r_state == ppsa_pkg::S_DONE && (!r_ovalid || i_ready)) begin
            r_st_out <= r_st;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_st_out;
    assign o_result_offset = r_roff;
    assign o_result_length = r_rlen;
    assign o_live_count    = r_olive;
    assign o_pages_busy    = r_obusy;
endmodule

/* rtl/core/ppsa_owner_mem.sv */
module ppsa_owner_mem #(
    parameter int DEPTH = 64,
    parameter int W     = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* bench/page_pool_suballocator_unit_test.sv */
module page_pool_suballocator_unit_test;

    localparam int PAGES     = 64;
    localparam int SLOTS     = 64;
    localparam int MAX_PAGES = 16;
    localparam int PAGE_SZ   = 4096;
    localparam int POOL_SZ   = PAGES * PAGE_SZ;
    localparam int IDLE_CAP  = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [17:0] i_byte_offset;
    logic [18:0] i_byte_size;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [17:0] o_result_offset;
    logic [18:0] o_result_length;
    logic [6:0]  o_live_count;
    logic [6:0]  o_pages_busy;

    page_pool_suballocator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_opcode(i_opcode), .i_byte_offset(i_byte_offset), .i_byte_size(i_byte_size),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_result_offset(o_result_offset),
        .o_result_length(o_result_length), .o_live_count(o_live_count),
        .o_pages_busy(o_pages_busy)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    typedef struct packed {
        ppsa_pkg::t_status status;
        logic [17:0]       offset;
        logic [18:0]       length;
        logic [6:0]        live;
        logic [6:0]        busy;
    } t_answer;

    // Shadow copy of the allocator state
    int unsigned owner_tag [PAGES];
    bit          slot_used [SLOTS];
    int unsigned slot_first[SLOTS];
    int unsigned slot_count[SLOTS];
    int unsigned live_allocs;
    int unsigned busy_total;
    int unsigned limit_reg;

    t_answer answer_q[$];
    int      fail_count;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      recv_hold;

    function automatic longint unsigned round_pages(longint unsigned bytes);
        return (bytes + PAGE_SZ - 1) / PAGE_SZ;
    endfunction

    // Owning slot plus one for the whole range, zero when not one live allocation
    function automatic int unsigned range_owner(longint unsigned off, longint unsigned size);
        longint unsigned first_pg;
        longint unsigned last_pg;
        longint unsigned a_lo;
        longint unsigned a_hi;
        int unsigned     own;
        first_pg = off / PAGE_SZ;
        last_pg  = (off + size - 1) / PAGE_SZ;
        own      = owner_tag[first_pg];
        if (own == 0 || own > SLOTS || !slot_used[own-1]) return 0;
        for (longint unsigned p = first_pg + 1; p <= last_pg; p++)
            if (owner_tag[p] != own) return 0;
        a_lo = longint'(slot_first[own-1]) * PAGE_SZ;
        a_hi = a_lo + longint'(slot_count[own-1]) * PAGE_SZ;
        if (off < a_lo || off + size > a_hi) return 0;
        return own;
    endfunction

    function automatic t_answer serve_request(ppsa_pkg::t_op op, longint unsigned off,
                                              longint unsigned size);
        t_answer         a;
        longint unsigned need;
        int unsigned     run;
        int              start;
        int              slot;
        int unsigned     own;
        a = '0;
        a.status = ppsa_pkg::ST_INVALID;
        case (op)
            ppsa_pkg::OP_ALLOC: begin
                if (size == 0) a.status = ppsa_pkg::ST_INVALID;
                else if (live_allocs >= limit_reg || live_allocs >= SLOTS)
                    a.status = ppsa_pkg::ST_NOSPACE;
                else begin
                    need = round_pages(size);
                    if (need > MAX_PAGES || need > PAGES) a.status = ppsa_pkg::ST_INVALID;
                    else begin
                        start = -1;
                        run   = 0;
                        for (int p = 0; p < PAGES && start < 0; p++) begin
                            run = owner_tag[p] != 0 ? 0 : run + 1;
                            if (run == need) start = int'(p + 1 - run);
                        end
                        slot = -1;
                        for (int s = 0; s < SLOTS && slot < 0; s++)
                            if (!slot_used[s]) slot = s;
                        if (start < 0 || slot < 0) a.status = ppsa_pkg::ST_NOSPACE;
                        else begin
                            slot_used[slot]  = 1;
                            slot_first[slot] = start;
                            slot_count[slot] = 32'(need);
                            for (int p = 0; p < need; p++) owner_tag[start+p] = slot + 1;
                            live_allocs++;
                            busy_total += 32'(need);
                            a.status = ppsa_pkg::ST_OK;
                            a.offset = 18'(start * PAGE_SZ);
                            a.length = 19'(need * PAGE_SZ);
                        end
                    end
                end
            end
            ppsa_pkg::OP_FREE: begin
                if (off >= POOL_SZ) a.status = ppsa_pkg::ST_OUTSIDE;
                else if (size == 0) a.status = ppsa_pkg::ST_INVALID;
                else begin
                    own = range_owner(off, 1);
                    if (own != 0 && off == longint'(slot_first[own-1]) * PAGE_SZ
                        && round_pages(size) == slot_count[own-1]) begin
                        a.status = ppsa_pkg::ST_OK;
                        a.offset = 18'(off);
                        a.length = 19'(slot_count[own-1] * PAGE_SZ);
                        for (int p = 0; p < slot_count[own-1]; p++)
                            owner_tag[slot_first[own-1]+p] = 0;
                        busy_total -= slot_count[own-1];
                        live_allocs--;
                        slot_used[own-1]  = 0;
                        slot_first[own-1] = 0;
                        slot_count[own-1] = 0;
                    end
                end
            end
            ppsa_pkg::OP_LOOKUP: begin
                if (off >= POOL_SZ) a.status = ppsa_pkg::ST_OUTSIDE;
                else if (size == 0) a.status = ppsa_pkg::ST_INVALID;
                else if (off + size > POOL_SZ) a.status = ppsa_pkg::ST_OUTSIDE;
                else begin
                    own = range_owner(off, size);
                    if (own != 0) begin
                        a.status = ppsa_pkg::ST_OK;
                        a.offset = 18'(slot_first[own-1] * PAGE_SZ);
                        a.length = 19'(slot_count[own-1] * PAGE_SZ);
                    end
                end
            end
            default: a.status = ppsa_pkg::ST_INVALID;
        endcase
        a.live = live_allocs[6:0];
        a.busy = busy_total[6:0];
        return a;
    endfunction

    // Record the expectation at the edge the transfer happens
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            answer_q.push_back(serve_request(ppsa_pkg::t_op'(i_opcode), i_byte_offset,
                                             i_byte_size));
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {ppsa_pkg::t_status'(o_status), o_result_offset, o_result_length,
                   o_live_count, o_pages_busy};
            if (answer_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t status exp %0d got %0d", $time, want.status, got.status);
                    fail_count++;
                end
                if (got.offset !== want.offset) begin
                    $display("%0t offset exp %h got %h", $time, want.offset, got.offset);
                    fail_count++;
                end
                if (got.length !== want.length) begin
                    $display("%0t length exp %h got %h", $time, want.length, got.length);
                    fail_count++;
                end
                if (got.live !== want.live) begin
                    $display("%0t live exp %0d got %0d", $time, want.live, got.live);
                    fail_count++;
                end
                if (got.busy !== want.busy) begin
                    $display("%0t busy exp %0d got %0d", $time, want.busy, got.busy);
                    fail_count++;
                end
            end
        end
    end

    // Drive the receiver ready; a hold forces a long stall
    always @(posedge i_clk) begin
        if (recv_hold) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one request and hold it until transferred; valid drops only on idle cycles
    task automatic send_request(ppsa_pkg::t_op op, logic [17:0] off, logic [18:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_byte_offset <= off;
        i_byte_size   <= size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Registers change only while the block is idle
    task automatic write_limit(int unsigned value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[6:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_reg = value & 7'h7f;
    endtask

    task automatic test_directed();
        send_request(ppsa_pkg::OP_ALLOC, 18'h3ffff, 19'd0);
        send_request(ppsa_pkg::OP_ALLOC, '0, 19'd1);
        send_request(ppsa_pkg::OP_ALLOC, '0, 19'd65536);
        send_request(ppsa_pkg::OP_ALLOC, '0, 19'd65537);
        send_request(ppsa_pkg::OP_ALLOC, '0, 19'h7ffff);
        send_request(ppsa_pkg::OP_ALLOC, '0, 19'd262144);
        send_request(ppsa_pkg::OP_LOOKUP, 18'd0, 19'd4096);
        send_request(ppsa_pkg::OP_LOOKUP, 18'd4000, 19'd200);
        send_request(ppsa_pkg::OP_LOOKUP, 18'd4096, 19'd65536);
        send_request(ppsa_pkg::OP_LOOKUP, 18'd4096, 19'd0);
        send_request(ppsa_pkg::OP_LOOKUP, 18'h3ffff, 19'd2);
        send_request(ppsa_pkg::OP_LOOKUP, 18'h3ffff, 19'h7ffff);
        send_request(ppsa_pkg::OP_FREE, 18'd4096, 19'd4096);
        send_request(ppsa_pkg::OP_FREE, 18'd4096, 19'd0);
        send_request(ppsa_pkg::OP_FREE, 18'd8192, 19'd65536);
        send_request(ppsa_pkg::OP_FREE, 18'd4096, 19'd65535);
        send_request(ppsa_pkg::OP_FREE, 18'd0, 19'd1);
        send_request(ppsa_pkg::OP_FREE, 18'd0, 19'd1);
        send_request(ppsa_pkg::OP_NONE, 18'h3ffff, 19'h7ffff);
        send_request(ppsa_pkg::OP_NONE, 18'd0, 19'd0);
    endtask

    // Mostly sensible requests aimed at live allocations, some noise
    task automatic random_request();
        int          pick;
        int          s;
        logic [17:0] off;
        logic [18:0] size;
        pick = $urandom_range(99);
        off  = 18'($urandom);
        size = 19'($urandom);
        s    = $urandom_range(SLOTS - 1);
        if (pick < 40) begin
            size = $urandom_range(4) == 0 ? 19'($urandom) : 19'($urandom_range(16 * PAGE_SZ));
            send_request(ppsa_pkg::OP_ALLOC, off, size);
        end else if (pick < 70) begin
            if (slot_used[s] && $urandom_range(4) != 0) begin
                off  = 18'(slot_first[s] * PAGE_SZ);
                size = 19'((slot_count[s] - 1) * PAGE_SZ + $urandom_range(1, PAGE_SZ));
            end
            send_request(ppsa_pkg::OP_FREE, off, size);
        end else if (pick < 92) begin
            if (slot_used[s]) begin
                off  = 18'(slot_first[s] * PAGE_SZ
                           + $urandom_range(slot_count[s] * PAGE_SZ - 1));
                size = 19'($urandom_range(1, 2 * PAGE_SZ));
            end
            send_request(ppsa_pkg::OP_LOOKUP, off, size);
        end else begin
            send_request(ppsa_pkg::t_op'($urandom_range(3)), off, size);
        end
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) random_request();
    endtask

    // Hold off the receiver long enough that the block stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge i_clk);
                recv_hold = 1'b0;
            end
            repeat (40) random_request();
        join
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_valid = 1'b0; i_opcode = '0; i_byte_offset = '0; i_byte_size = '0;
        i_ready = 1'b0; recv_hold = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        fail_count = 0; idle_cycles = 0;
        live_allocs = 0; busy_total = 0; limit_reg = 64;
        for (int i = 0; i < PAGES; i++) owner_tag[i] = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 0; slot_first[i] = 0; slot_count[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        write_limit(0);
        test_random(30, 0, 0);
        write_limit(1);
        test_random(60, 0, 0);
        write_limit(3);
        test_random(300, 70, 0);
        write_limit(7'h7f);
        test_random(500, 0, 70);
        test_backpressure();
        write_limit(5);
        test_random(300, 34, 34);
        write_limit(64);
        test_random(800, 34, 34);
        drain_results();

        if (fail_count == 0 && answer_q.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
